/* hw/rtl/upn_pkg.sv */
// upn_pkg: shared types and constants of the polygon unit normal block.
// Used by upn_ctrl, upn_datapath and polygon_unit_normal_top; no dependencies.
`timescale 1ns / 1ps

package upn_pkg;

    // Default face size limit
    localparam int MAX_FACE_VERTICES_DEF = 64;

    // Fixed widths of the arithmetic
    localparam int COORD_W = 16;   // Q8.8 vertex coordinate
    localparam int SUM_W   = 48;   // Newell accumulator, Q32.16
    localparam int HALF_W  = 24;   // half of an accumulator magnitude
    localparam int SQ_W    = 96;   // sum of squares, Q64.32
    localparam int ROOT_W  = 48;   // normal length, Q32.16
    localparam int REM_W   = 52;   // square root remainder
    localparam int DIV_W   = 63;   // divider remainder
    localparam int Q_W     = 15;   // unit component magnitude
    localparam int NRM_W   = 16;   // unit component, Q2.14
    localparam int AREA_W  = 47;   // face area, Q31.16
    localparam int UNIT_SH = 14;   // scale of Q2.14
    localparam int LIMIT_W = 32;   // zero area limit register

    // Step counts of the face end sequence
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = Q_W;

    // Register address decode (byte address bit 2 selects the register)
    localparam int  PADDR_W          = 3;
    localparam logic REG_ZERO_LIMIT  = 1'b0;
    localparam logic [LIMIT_W-1:0] ZERO_LIMIT_RESET = 32'd1;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FEW  = 2'd1,
        STAT_ZERO = 2'd2,
        STAT_MANY = 2'd3
    } status_t;

    // Square partial product selects
    typedef enum logic [1:0] {
        PART_LL = 2'd0,
        PART_LH = 2'd1,
        PART_HH = 2'd2
    } part_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE_MUL,
        ST_EDGE_ADD,
        ST_CHECK,
        ST_CLOSE_MUL,
        ST_CLOSE_ADD,
        ST_SQ_MUL,
        ST_SQ_ADD,
        ST_SQRT,
        ST_LIMIT,
        ST_DIV_INIT,
        ST_DIV,
        ST_OUT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    edge_mul;
        logic    edge_add;
        logic    close_sel;
        logic    set_status;
        status_t status;
        logic    sq_clear;
        logic    sq_mul;
        logic    sq_add;
        logic [1:0] comp;
        part_t   part;
        logic    sqrt_step;
        logic    div_init;
        logic    div_step;
        logic    div_store;
        logic    out_load;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic last;
        logic count_over;
        logic count_lt3;
        logic len_le_limit;
        logic out_free;
    } stat_t;

endpackage

/* hw/rtl/upn_ctrl.sv */
// upn_ctrl: sequencer of the polygon unit normal block.
// Depends on upn_pkg; drives upn_datapath through cmd_t and reads stat_t.
`timescale 1ns / 1ps

module upn_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  upn_pkg::stat_t stat,
    output upn_pkg::cmd_t  cmd
);

    upn_pkg::state_t state_reg, state_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic [1:0]      comp_reg, comp_next;
    upn_pkg::part_t  part_reg, part_next;

    // State and step counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= upn_pkg::ST_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
            part_reg  <= upn_pkg::PART_LL;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
            part_reg  <= part_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        part_next  = part_reg;
        cmd        = '0;
        cmd.comp   = comp_reg;
        cmd.part   = part_reg;
        s_tready   = 1'b0;

        unique case (state_reg)
            upn_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = upn_pkg::ST_EDGE_MUL;
                end
            end
            upn_pkg::ST_EDGE_MUL:
            begin
                cmd.edge_mul = 1'b1;
                state_next   = upn_pkg::ST_EDGE_ADD;
            end
            upn_pkg::ST_EDGE_ADD:
            begin
                cmd.edge_add = 1'b1;
                state_next   = stat.last ? upn_pkg::ST_CHECK : upn_pkg::ST_IDLE;
            end
            upn_pkg::ST_CHECK:
            begin
                // Pick the short exits before the closing edge
                if (stat.count_over)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = upn_pkg::STAT_MANY;
                    state_next     = upn_pkg::ST_OUT;
                end
                else if (stat.count_lt3)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = upn_pkg::STAT_FEW;
                    state_next     = upn_pkg::ST_OUT;
                end
                else
                begin
                    state_next = upn_pkg::ST_CLOSE_MUL;
                end
            end
            upn_pkg::ST_CLOSE_MUL:
            begin
                cmd.edge_mul  = 1'b1;
                cmd.close_sel = 1'b1;
                state_next    = upn_pkg::ST_CLOSE_ADD;
            end
            upn_pkg::ST_CLOSE_ADD:
            begin
                cmd.edge_add  = 1'b1;
                cmd.close_sel = 1'b1;
                cmd.sq_clear  = 1'b1;
                comp_next     = '0;
                part_next     = upn_pkg::PART_LL;
                state_next    = upn_pkg::ST_SQ_MUL;
            end
            upn_pkg::ST_SQ_MUL:
            begin
                cmd.sq_mul = 1'b1;
                state_next = upn_pkg::ST_SQ_ADD;
            end
            upn_pkg::ST_SQ_ADD:
            begin
                cmd.sq_add = 1'b1;
                // Advance over three partial products of three components
                if (part_reg == upn_pkg::PART_HH)
                begin
                    part_next = upn_pkg::PART_LL;
                    if (comp_reg == 2'd2)
                    begin
                        cnt_next   = 6'(upn_pkg::SQRT_STEPS - 1);
                        state_next = upn_pkg::ST_SQRT;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = upn_pkg::ST_SQ_MUL;
                    end
                end
                else
                begin
                    part_next  = (part_reg == upn_pkg::PART_LL) ? upn_pkg::PART_LH
                                                                : upn_pkg::PART_HH;
                    state_next = upn_pkg::ST_SQ_MUL;
                end
            end
            upn_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                    state_next = upn_pkg::ST_LIMIT;
            end
            upn_pkg::ST_LIMIT:
            begin
                cmd.set_status = 1'b1;
                if (stat.len_le_limit)
                begin
                    cmd.status = upn_pkg::STAT_ZERO;
                    state_next = upn_pkg::ST_OUT;
                end
                else
                begin
                    cmd.status = upn_pkg::STAT_OK;
                    comp_next  = '0;
                    state_next = upn_pkg::ST_DIV_INIT;
                end
            end
            upn_pkg::ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = 6'(upn_pkg::DIV_STEPS - 1);
                state_next   = upn_pkg::ST_DIV;
            end
            upn_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    cmd.div_store = 1'b1;
                    if (comp_reg == 2'd2)
                    begin
                        state_next = upn_pkg::ST_OUT;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = upn_pkg::ST_DIV_INIT;
                    end
                end
            end
            upn_pkg::ST_OUT:
            begin
                // Hold until the output register is free
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = upn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = upn_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/upn_datapath.sv */
// upn_datapath: vertex registers, Newell accumulators, squarer, square root,
// divider and output register. Depends on upn_pkg; commanded by upn_ctrl.
`timescale 1ns / 1ps

module upn_datapath
#(
    parameter int MAX_FACE_VERTICES = upn_pkg::MAX_FACE_VERTICES_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  upn_pkg::cmd_t                      cmd,
    output upn_pkg::stat_t                     stat,
    input  logic [3*upn_pkg::COORD_W-1:0]      vertex_in,
    input  logic                               last_in,
    input  logic [upn_pkg::LIMIT_W-1:0]        zero_area_limit,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [upn_pkg::NRM_W-1:0]   normal_x,
    output logic signed [upn_pkg::NRM_W-1:0]   normal_y,
    output logic signed [upn_pkg::NRM_W-1:0]   normal_z,
    output logic [upn_pkg::AREA_W-1:0]         face_area,
    output upn_pkg::status_t                   status
);

    localparam int CNT_W = $clog2(MAX_FACE_VERTICES + 2);
    localparam int CW    = upn_pkg::COORD_W;
    localparam int SW    = upn_pkg::SUM_W;
    localparam int PW    = 2 * (CW + 1);

    // Face state
    logic signed [CW-1:0] cur_reg   [3];
    logic signed [CW-1:0] first_reg [3];
    logic signed [CW-1:0] prev_reg  [3];
    logic signed [SW-1:0] sums_reg  [3];
    logic signed [PW-1:0] prod_reg  [3];
    logic [CNT_W-1:0]     count_reg;
    logic                 last_reg;
    logic                 edge_en_reg;

    // Face end arithmetic
    logic [2*upn_pkg::HALF_W-1:0] sq_prod_reg;
    upn_pkg::part_t               sq_part_reg;
    logic [upn_pkg::SQ_W-1:0]     acc_reg;
    logic [upn_pkg::REM_W-1:0]    rem_reg;
    logic [upn_pkg::ROOT_W-1:0]   root_reg;
    logic [upn_pkg::DIV_W-1:0]    drem_reg;
    logic [upn_pkg::DIV_W-1:0]    dvs_reg;
    logic [upn_pkg::Q_W-1:0]      q_reg;
    logic signed [upn_pkg::NRM_W-1:0] nrm_reg [3];
    upn_pkg::status_t             status_reg;
    logic                         out_valid_reg;

    // Edge operands and products
    logic signed [CW-1:0] ea [3];
    logic signed [CW-1:0] eb [3];
    logic signed [CW:0]   dif [3];
    logic signed [CW:0]   add [3];

    // Magnitude of the selected accumulator
    logic signed [SW-1:0] sel_sum;
    logic [SW-1:0]        sel_mag;
    logic [upn_pkg::HALF_W-1:0] mag_lo, mag_hi;
    logic [upn_pkg::HALF_W-1:0] mul_a, mul_b;
    logic [upn_pkg::SQ_W-1:0]   sq_term;

    // Square root step
    logic [upn_pkg::REM_W-1:0] rem_sh, trial;
    logic                      root_ge;

    // Divider step
    logic                      div_ge;
    logic [upn_pkg::Q_W-1:0]   q_next;
    logic [upn_pkg::NRM_W-1:0] q_ext;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ea[i] = cmd.close_sel ? cur_reg[i] : prev_reg[i];
            eb[i] = cmd.close_sel ? first_reg[i] : cur_reg[i];
            dif[i] = {ea[i][CW-1], ea[i]} - {eb[i][CW-1], eb[i]};
            add[i] = {ea[i][CW-1], ea[i]} + {eb[i][CW-1], eb[i]};
        end
    end

    assign sel_sum = sums_reg[cmd.comp];
    assign sel_mag = sel_sum[SW-1] ? SW'(-sel_sum) : SW'(sel_sum);
    assign mag_lo  = sel_mag[upn_pkg::HALF_W-1:0];
    assign mag_hi  = sel_mag[SW-1:upn_pkg::HALF_W];

    // Choose the halves for the partial product
    always_comb
    begin
        case (cmd.part)
            upn_pkg::PART_LL:
            begin
                mul_a = mag_lo;
                mul_b = mag_lo;
            end
            upn_pkg::PART_LH:
            begin
                mul_a = mag_lo;
                mul_b = mag_hi;
            end
            default:
            begin
                mul_a = mag_hi;
                mul_b = mag_hi;
            end
        endcase
    end

    // Align the registered partial product (cross term counted twice)
    always_comb
    begin
        case (sq_part_reg)
            upn_pkg::PART_LL: sq_term = upn_pkg::SQ_W'(sq_prod_reg);
            upn_pkg::PART_LH: sq_term = upn_pkg::SQ_W'(sq_prod_reg) << (upn_pkg::HALF_W + 1);
            default:          sq_term = upn_pkg::SQ_W'(sq_prod_reg) << (2 * upn_pkg::HALF_W);
        endcase
    end

    assign rem_sh  = {rem_reg[upn_pkg::REM_W-3:0], acc_reg[upn_pkg::SQ_W-1 -: 2]};
    assign trial   = upn_pkg::REM_W'({root_reg, 2'b01});
    assign root_ge = (rem_sh >= trial);

    assign div_ge = (drem_reg >= dvs_reg);
    assign q_next = {q_reg[upn_pkg::Q_W-2:0], div_ge};
    assign q_ext  = upn_pkg::NRM_W'(q_next);

    // Vertex intake, count and Newell accumulation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            last_reg    <= 1'b0;
            edge_en_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                first_reg[i] <= '0;
                prev_reg[i]  <= '0;
                sums_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                last_reg    <= last_in;
                edge_en_reg <= (count_reg != '0)
                            && (count_reg <= CNT_W'(MAX_FACE_VERTICES));
                if (count_reg == '0)
                begin
                    count_reg <= CNT_W'(1);
                    for (int i = 0; i < 3; i++)
                        first_reg[i] <= vertex_in[i*CW +: CW];
                end
                else if (count_reg <= CNT_W'(MAX_FACE_VERTICES))
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.edge_add)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (edge_en_reg || cmd.close_sel)
                        sums_reg[i] <= sums_reg[i] + SW'(prod_reg[i]);
                    if (!cmd.close_sel)
                        prev_reg[i] <= cur_reg[i];
                end
            end
            if (cmd.out_load)
            begin
                // Clear face state for the next face
                count_reg <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    first_reg[i] <= '0;
                    prev_reg[i]  <= '0;
                    sums_reg[i]  <= '0;
                end
            end
        end
    end

    // Payload registers: current vertex and edge products
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 3; i++)
                cur_reg[i] <= vertex_in[i*CW +: CW];
        end
        if (cmd.edge_mul)
        begin
            prod_reg[0] <= dif[1] * add[2];
            prod_reg[1] <= dif[2] * add[0];
            prod_reg[2] <= dif[0] * add[1];
        end
    end

    // Sum of squares, square root and division
    always_ff @(posedge clk)
    begin
        if (cmd.sq_mul)
        begin
            sq_prod_reg <= mul_a * mul_b;
            sq_part_reg <= cmd.part;
        end
        if (cmd.sq_clear)
        begin
            acc_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sq_add)
        begin
            acc_reg <= acc_reg + sq_term;
        end
        else if (cmd.sqrt_step)
        begin
            acc_reg  <= acc_reg << 2;
            rem_reg  <= root_ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[upn_pkg::ROOT_W-2:0], root_ge};
        end
        if (cmd.div_init)
        begin
            drem_reg <= (upn_pkg::DIV_W'(sel_mag) << upn_pkg::UNIT_SH)
                      + upn_pkg::DIV_W'(root_reg >> 1);
            dvs_reg  <= upn_pkg::DIV_W'(root_reg) << upn_pkg::UNIT_SH;
            q_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_ge)
                drem_reg <= drem_reg - dvs_reg;
            dvs_reg <= dvs_reg >> 1;
            q_reg   <= q_next;
        end
        if (cmd.div_store)
            nrm_reg[cmd.comp] <= sel_sum[SW-1] ? -q_ext : q_ext;
        if (cmd.set_status)
            status_reg <= cmd.status;
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status    <= status_reg;
            normal_x  <= (status_reg == upn_pkg::STAT_OK) ? nrm_reg[0] : '0;
            normal_y  <= (status_reg == upn_pkg::STAT_OK) ? nrm_reg[1] : '0;
            normal_z  <= (status_reg == upn_pkg::STAT_OK) ? nrm_reg[2] : '0;
            face_area <= (status_reg == upn_pkg::STAT_OK || status_reg == upn_pkg::STAT_ZERO)
                       ? upn_pkg::AREA_W'(root_reg >> 1) : '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign stat.last         = last_reg;
    assign stat.count_over   = (count_reg > CNT_W'(MAX_FACE_VERTICES));
    assign stat.count_lt3    = (count_reg < CNT_W'(3));
    assign stat.len_le_limit = (root_reg <= upn_pkg::ROOT_W'(zero_area_limit));
    assign stat.out_free     = !out_valid_reg || out_ready;

endmodule

/* hw/rtl/polygon_unit_normal_top.sv */
// polygon_unit_normal_top: Newell unit normal and area of polygon faces.
// Depends on upn_pkg, upn_ctrl and upn_datapath.
//
// Input stream s_*: one vertex per transaction, tlast on the last vertex of
// a face. Output stream m_*: one result per face. Register port: APB-style,
// zero_area_limit at byte address 0.
// A vertex passes through accept, edge multiply and accumulate before the
// next is accepted. The face end runs a count check, closing edge, sum of
// squares (nine 24x24 partial products through one multiplier), square
// root (one root bit a cycle), limit check, division (three components,
// 15 quotient bits each through one shared divider) and output load.
// The result sits in the output register until taken; while it waits the
// next face's vertices are accepted. If the next face ends before the old
// result is taken, the block holds in its output state and stops accepting.
// Reset clears the face state, drops the output valid and sets
// zero_area_limit to 1.
`timescale 1ns / 1ps

module polygon_unit_normal_top
#(
    parameter int MAX_FACE_VERTICES = upn_pkg::MAX_FACE_VERTICES_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [47:0]                  s_tdata,  // vertex_x, vertex_y, vertex_z
    input  logic                         s_tlast,  // last_of_face
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [95:0]                  m_tdata,  // normal_x, normal_y, normal_z, face_area, 0
    output logic [1:0]                   m_tuser,  // status
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [upn_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    upn_pkg::cmd_t   cmd;
    upn_pkg::stat_t  stat;
    upn_pkg::status_t status;
    logic [upn_pkg::LIMIT_W-1:0] limit_reg;
    logic signed [upn_pkg::NRM_W-1:0] normal_x, normal_y, normal_z;
    logic [upn_pkg::AREA_W-1:0] face_area;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= upn_pkg::ZERO_LIMIT_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == upn_pkg::REG_ZERO_LIMIT)
            limit_reg <= pwdata;
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == upn_pkg::REG_ZERO_LIMIT) ? limit_reg : '0;

    upn_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    upn_datapath
    #(
        .MAX_FACE_VERTICES (MAX_FACE_VERTICES)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .vertex_in       (s_tdata),
        .last_in         (s_tlast),
        .zero_area_limit (limit_reg),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .normal_x        (normal_x),
        .normal_y        (normal_y),
        .normal_z        (normal_z),
        .face_area       (face_area),
        .status          (status)
    );

    // Pack the result transaction
    assign m_tdata = {1'b0, face_area, normal_z, normal_y, normal_x};
    assign m_tuser = status;

endmodule

/* dv/tb.sv */
// tb: self-checking testbench for polygon_unit_normal_top (Newell face normal).
// Depends on upn_pkg and the RTL of polygon_unit_normal_top; needs no files.
`timescale 1ns / 1ps

module tb;

    localparam int MAX_VERTS  = upn_pkg::MAX_FACE_VERTICES_DEF;
    localparam int WATCHDOG   = 20000;
    localparam logic [47:0] AREA_SAT = 48'h7FFF_FFFF_FFFF;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic        last;
    } vertex_t;

    typedef struct packed {
        logic [15:0]      nx;
        logic [15:0]      ny;
        logic [15:0]      nz;
        logic [46:0]      area;
        upn_pkg::status_t status;
    } face_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [upn_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    polygon_unit_normal_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state: face accumulators and the area limit
    logic [31:0]        area_limit;
    logic signed [63:0] face_first [3];
    logic signed [63:0] face_prev [3];
    logic signed [63:0] newell_sum [3];
    int                 face_count;

    vertex_t      vertex_queue [$];
    face_result_t expected_faces [$];
    int           error_count;
    int           faces_checked;
    int           vertices_sent;
    int           idle_cycles;
    int           hold_off;
    bit           big_hold_req;
    int           send_gap;
    int           recv_gap;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic void clear_face_state();
        for (int i = 0; i < 3; i++)
        begin
            face_first[i] = 0;
            face_prev[i] = 0;
            newell_sum[i] = 0;
        end
        face_count = 0;
    endfunction

    function automatic void add_newell_edge(logic signed [63:0] a [3],
                                            logic signed [63:0] b [3]);
        newell_sum[0] += (a[1] - b[1]) * (a[2] + b[2]);
        newell_sum[1] += (a[2] - b[2]) * (a[0] + b[0]);
        newell_sum[2] += (a[0] - b[0]) * (a[1] + b[1]);
    endfunction

    function automatic logic [47:0] isqrt(logic [127:0] v);
        logic [47:0] r;
        logic [47:0] t;
        r = 0;
        for (int b = 47; b >= 0; b--)
        begin
            t = r | (48'd1 << b);
            if ({80'd0, t} * {80'd0, t} <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic logic [15:0] unit_part(logic signed [63:0] n, logic [47:0] len);
        logic [127:0] m;
        logic [127:0] q;
        m = (n < 0) ? -n : n;
        q = (m * 128'd16384 + len / 2) / len;
        return (n < 0) ? -q[15:0] : q[15:0];
    endfunction

    // Advance the predictor by one accepted vertex
    task automatic predict_vertex(vertex_t v);
        logic signed [63:0] cur [3];
        face_result_t r;
        logic [127:0] sq;
        logic [127:0] m;
        logic [47:0]  len;
        cur[0] = 64'(signed'(v.x));
        cur[1] = 64'(signed'(v.y));
        cur[2] = 64'(signed'(v.z));
        if (face_count == 0)
        begin
            face_first = cur;
            face_count = 1;
        end
        else if (face_count <= MAX_VERTS)
        begin
            add_newell_edge(face_prev, cur);
            face_count++;
        end
        face_prev = cur;
        if (!v.last)
            return;
        r = '0;
        if (face_count > MAX_VERTS)
            r.status = upn_pkg::STAT_MANY;
        else if (face_count < 3)
            r.status = upn_pkg::STAT_FEW;
        else
        begin
            add_newell_edge(cur, face_first);
            sq = 0;
            for (int i = 0; i < 3; i++)
            begin
                m = (newell_sum[i] < 0) ? -newell_sum[i] : newell_sum[i];
                sq += m * m;
            end
            len = isqrt(sq);
            r.area = ((len / 2) > AREA_SAT) ? AREA_SAT[46:0] : 47'(len / 2);
            if (len <= {16'd0, area_limit})
                r.status = upn_pkg::STAT_ZERO;
            else
            begin
                r.status = upn_pkg::STAT_OK;
                r.nx = unit_part(newell_sum[0], len);
                r.ny = unit_part(newell_sum[1], len);
                r.nz = unit_part(newell_sum[2], len);
            end
        end
        expected_faces = {expected_faces, r};
        clear_face_state();
    endtask

    // Driver: offer queued vertices with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_vertex({s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tlast});
                vertices_sent++;
                send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            end
            if ((!s_tvalid || s_tready) && vertex_queue.size() > 0 && send_gap == 0)
            begin
                vertex_t v;
                v = vertex_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {v.z, v.y, v.x};
                s_tlast  <= v.last;
            end
            else if (!s_tvalid || s_tready)
            begin
                s_tvalid <= 1'b0;
                if (send_gap > 0)
                    send_gap--;
            end
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                face_result_t exp_r;
                face_result_t got;
                got.nx = m_tdata[15:0];
                got.ny = m_tdata[31:16];
                got.nz = m_tdata[47:32];
                got.area = m_tdata[94:48];
                got.status = upn_pkg::status_t'(m_tuser);
                if (expected_faces.size() == 0)
                begin
                    $display("%0t unexpected result %h", $time, got);
                    error_count++;
                end
                else
                begin
                    exp_r = expected_faces.pop_front();
                    if (got.nx !== exp_r.nx || got.ny !== exp_r.ny || got.nz !== exp_r.nz)
                    begin
                        $display("%0t normal mismatch: expected %h %h %h actual %h %h %h", $time,
                                 exp_r.nx, exp_r.ny, exp_r.nz, got.nx, got.ny, got.nz);
                        error_count++;
                    end
                    if (got.area !== exp_r.area)
                    begin
                        $display("%0t area mismatch: expected %h actual %h", $time,
                                 exp_r.area, got.area);
                        error_count++;
                    end
                    if (got.status !== exp_r.status)
                    begin
                        $display("%0t status mismatch: expected %0d actual %0d", $time,
                                 exp_r.status, got.status);
                        error_count++;
                    end
                end
                faces_checked++;
                recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            end
            // Hold off for a long stretch on request, else random stalls
            if (big_hold_req && hold_off == 0)
            begin
                hold_off = 600;
                big_hold_req = 0;
            end
            if (hold_off > 0)
            begin
                hold_off--;
                m_tready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: count cycles with no transaction on either stream
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("watchdog expired at %0t", $time);
            $display("polygon_unit_normal_top verification failed");
            $finish;
        end
    end

    task automatic apb_write(logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= '0;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        area_limit = value;
    endtask

    task automatic push_vertex(int x, int y, int z, bit last);
        vertex_t v;
        v.x = 16'(x);
        v.y = 16'(y);
        v.z = 16'(z);
        v.last = last;
        vertex_queue = {vertex_queue, v};
    endtask

    // Queue a face of n vertices; small coordinates with some chance of full range
    task automatic push_random_face(int n);
        bit wide;
        wide = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < n; i++)
        begin
            if (wide)
                push_vertex($urandom, $urandom, $urandom, i == n - 1);
            else
                push_vertex($signed($urandom_range(0, 4095)) - 2048,
                            $signed($urandom_range(0, 4095)) - 2048,
                            $signed($urandom_range(0, 4095)) - 2048, i == n - 1);
        end
    endtask

    // Wait until the queue drains and every result is in, then let the block settle
    task automatic drain();
        while (vertex_queue.size() > 0 || s_tvalid || expected_faces.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        int n;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        area_limit = upn_pkg::ZERO_LIMIT_RESET;
        big_hold_req = 0;
        clear_face_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, degenerate faces, zero area, overflowing face
        push_vertex(0, 0, 0, 1);
        push_vertex(256, 0, 0, 0); push_vertex(0, 256, 0, 1);
        push_vertex(0, 0, 0, 0); push_vertex(256, 0, 0, 0); push_vertex(0, 256, 0, 1);
        push_vertex(-32768, -32768, -32768, 0); push_vertex(32767, -32768, 32767, 0);
        push_vertex(-32768, 32767, 32767, 1);
        push_vertex(32767, 32767, 32767, 0); push_vertex(-32768, -32768, 32767, 0);
        push_vertex(32767, -32768, -32768, 0); push_vertex(-32768, 32767, -32768, 1);
        push_vertex(5, 5, 5, 0); push_vertex(5, 5, 5, 0); push_vertex(5, 5, 5, 1);
        push_vertex(0, 0, 0, 0); push_vertex(1, 0, 0, 0); push_vertex(0, 1, 0, 1);
        drain();
        for (int i = 0; i < MAX_VERTS + 3; i++)
            push_vertex(i * 37, -i * 11, i * i, i == MAX_VERTS + 2);
        for (int i = 0; i < MAX_VERTS; i++)
            push_vertex((i % 2) * 512, (i % 3) * 300, i * 9, i == MAX_VERTS - 1);
        drain();

        // Random faces under several area limits, extremes included
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: apb_write(32'd0);
                1: apb_write(32'hFFFF_FFFF);
                2: apb_write($urandom_range(0, 32'h0100_0000));
                default: apb_write(32'd1);
            endcase
            if (phase == 2)
                big_hold_req = 1;
            while (vertices_sent + vertex_queue.size() < 90 * (phase + 1) + 140)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
                push_random_face(n);
            end
            drain();
        end

        if (expected_faces.size() > 0)
        begin
            $display("%0t %0d results never arrived", $time, expected_faces.size());
            error_count++;
        end
        $display("Run covered %0d vertices and %0d faces over four area limits,",
                 vertices_sent, faces_checked);
        $display("including short, flat, overflowing and full-range faces.");
        if (error_count == 0)
            $display("polygon_unit_normal_top verification clean");
        else
            $display("polygon_unit_normal_top verification failed");
        $finish;
    end
endmodule
